[src/detp_pkg.sv]
package detp_pkg;

	// default sizes
	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_ALPHABET = 26;

	// fixed field widths
	localparam int SYM_W   = 5;
	localparam int ROOM_W  = 11;
	localparam int TOTAL_W = 20;
	localparam int COUNT_W = 11;
	localparam int LEN_W   = 11;

	// push side codes
	localparam logic CMD_BACK  = 1'b0;
	localparam logic CMD_FRONT = 1'b1;

	// result status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// root node numbers
	localparam int ODD_ROOT  = 0;
	localparam int EVEN_ROOT = 1;

	// controller to datapath commands
	typedef struct packed {
		logic restart;
		logic clr_step;
		logic start;
		logic reject;
		logic node_use;
		logic walk_next;
		logic caddr_load;
		logic create;
		logic hit;
		logic link_even;
		logic phase1;
		logic link_found;
		logic depth_use;
		logic end_use;
		logic finish;
	} detp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rej;
		logic clr_last;
		logic match;
		logic child_zero;
		logic len_odd;
	} detp_stat_t;

endpackage

[src/detp_if.sv]
// push request channel
interface detp_push_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [detp_pkg::SYM_W-1:0] symbol;
	modport source (output valid, cmd, symbol, input ready);
	modport sink (input valid, cmd, symbol, output ready);
endinterface

// result channel
interface detp_result_if;
	logic                         valid;
	logic                         ready;
	logic [detp_pkg::TOTAL_W-1:0] total_palindromes;
	logic [detp_pkg::COUNT_W-1:0] distinct_palindromes;
	logic [detp_pkg::LEN_W-1:0]   end_palindrome_len;
	logic                         status;
	modport source (output valid, total_palindromes, distinct_palindromes,
		end_palindrome_len, status, input ready);
	modport sink (input valid, total_palindromes, distinct_palindromes,
		end_palindrome_len, status, output ready);
endinterface

// front room write channel
interface detp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [detp_pkg::ROOM_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/detp_ram.sv]
module detp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/detp_ctrl.sv]
module detp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  logic                  result_ready,
	input  logic                  cfg_fire,
	input  detp_pkg::detp_stat_t  stat,
	output detp_pkg::detp_cmd_t   cmd,
	output logic                  push_ready,
	output logic                  result_valid
);
	import detp_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_NRD  = 4'd2;
	localparam logic [3:0] ST_NUSE = 4'd3;
	localparam logic [3:0] ST_SRD  = 4'd4;
	localparam logic [3:0] ST_SCMP = 4'd5;
	localparam logic [3:0] ST_CADR = 4'd6;
	localparam logic [3:0] ST_CRD  = 4'd7;
	localparam logic [3:0] ST_CCHK = 4'd8;
	localparam logic [3:0] ST_DRD  = 4'd9;
	localparam logic [3:0] ST_DUSE = 4'd10;
	localparam logic [3:0] ST_ERD  = 4'd11;
	localparam logic [3:0] ST_EUSE = 4'd12;
	localparam logic [3:0] ST_FIN  = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0] st_q;
	logic [3:0] nxt;
	logic       ph_q;

	assign push_ready   = (st_q == ST_IDLE);
	assign result_valid = (st_q == ST_OUT);

	// next state and commands
	always_comb begin
		cmd = '0;
		nxt = st_q;
		if (cfg_fire) begin
			cmd.restart = 1'b1;
			nxt = ST_CLR;
		end else begin
			unique case (st_q)
				ST_CLR: begin
					cmd.clr_step = 1'b1;
					if (stat.clr_last) nxt = ST_IDLE;
				end
				ST_IDLE: begin
					if (push_valid) begin
						if (stat.rej) begin
							cmd.reject = 1'b1;
							nxt = ST_OUT;
						end else begin
							cmd.start = 1'b1;
							nxt = ST_NRD;
						end
					end
				end
				ST_NRD: nxt = ST_NUSE;
				ST_NUSE: begin
					cmd.node_use = 1'b1;
					nxt = ST_SRD;
				end
				ST_SRD: nxt = ST_SCMP;
				ST_SCMP: begin
					if (stat.match) begin
						nxt = ST_CADR;
					end else begin
						cmd.walk_next = 1'b1;
						nxt = ST_NRD;
					end
				end
				ST_CADR: begin
					cmd.caddr_load = 1'b1;
					nxt = ST_CRD;
				end
				ST_CRD: nxt = ST_CCHK;
				ST_CCHK: begin
					if (ph_q) begin
						cmd.link_found = 1'b1;
						nxt = ST_DRD;
					end else if (!stat.child_zero) begin
						cmd.hit = 1'b1;
						nxt = ST_ERD;
					end else if (stat.len_odd) begin
						cmd.create = 1'b1;
						cmd.link_even = 1'b1;
						nxt = ST_DRD;
					end else begin
						cmd.create = 1'b1;
						cmd.phase1 = 1'b1;
						nxt = ST_NRD;
					end
				end
				ST_DRD: nxt = ST_DUSE;
				ST_DUSE: begin
					cmd.depth_use = 1'b1;
					nxt = ST_FIN;
				end
				ST_ERD: nxt = ST_EUSE;
				ST_EUSE: begin
					cmd.end_use = 1'b1;
					nxt = ST_FIN;
				end
				ST_FIN: begin
					cmd.finish = 1'b1;
					nxt = ST_OUT;
				end
				ST_OUT: begin
					if (result_ready) nxt = ST_IDLE;
				end
				default: nxt = ST_CLR;
			endcase
		end
	end

	// state and walk phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			ph_q <= 1'b0;
		end else begin
			st_q <= nxt;
			if (cmd.start) ph_q <= 1'b0;
			else if (cmd.phase1) ph_q <= 1'b1;
		end
	end

endmodule

[src/detp_dp.sv]
module detp_dp #(
	parameter int CAPACITY = detp_pkg::DEF_CAPACITY,
	parameter int ALPHABET = detp_pkg::DEF_ALPHABET
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  detp_pkg::detp_cmd_t          cmd,
	output detp_pkg::detp_stat_t         stat,
	input  logic                         push_cmd,
	input  logic [detp_pkg::SYM_W-1:0]   push_symbol,
	input  logic [detp_pkg::ROOM_W-1:0]  cfg_data,
	output logic [detp_pkg::TOTAL_W-1:0] total_palindromes,
	output logic [detp_pkg::COUNT_W-1:0] distinct_palindromes,
	output logic [detp_pkg::LEN_W-1:0]   end_palindrome_len,
	output logic                         status
);
	import detp_pkg::*;

	localparam int NODE_MAX = CAPACITY + 2;
	localparam int NW       = $clog2(NODE_MAX);
	localparam int NCW      = $clog2(NODE_MAX + 1);
	localparam int DW       = $clog2(CAPACITY + 1);
	localparam int PW       = $clog2(CAPACITY + 1) + 1;
	localparam int PPW      = PW + 1;
	localparam int SW       = $clog2(CAPACITY);
	localparam int CHD      = NODE_MAX * ALPHABET;
	localparam int CW       = $clog2(CHD);
	localparam int NODE_W   = PW + NW + DW;
	localparam logic signed [PW-1:0]  CAP_P = PW'(CAPACITY);
	localparam logic signed [PPW-1:0] CAP_PP = PPW'(CAPACITY);

	// control registers
	logic signed [PW-1:0] fi_q, bi_q;
	logic [NW-1:0]        pre_q, suf_q;
	logic signed [PW-1:0] pre_len_q, suf_len_q;
	logic [NCW-1:0]       ncount_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CW-1:0]        clr_q;

	// working registers
	logic                  front_q;
	logic [SYM_W-1:0]      c_q;
	logic [NW-1:0]         cur_q, link_q, new_q, end_q;
	logic signed [PW-1:0]  len_q, new_len_q, end_len_q;
	logic [DW-1:0]         end_depth_q;
	logic signed [PPW-1:0] p_q;
	logic                  inr_q;
	logic [CW-1:0]         caddr_q;

	// memory ports
	logic [SYM_W-1:0]  sym_rdata;
	logic [NODE_W-1:0] node_rdata;
	logic [NW-1:0]     child_rdata;
	logic              child_we;
	logic [CW-1:0]     child_waddr;
	logic [NW-1:0]     child_wdata;

	// decoded node entry and helpers
	logic signed [PW-1:0]  nd_len;
	logic [NW-1:0]         nd_link;
	logic [DW-1:0]         nd_dep;
	logic signed [PW-1:0]  room;
	logic signed [PW-1:0]  sel_len;
	logic signed [PPW-1:0] p_nxt;
	logic [TOTAL_W-1:0]    total_nxt;

	function automatic logic [LEN_W-1:0] len_out(input logic signed [PW-1:0] l);
		len_out = (l > 0) ? LEN_W'(l) : '0;
	endfunction

	// symbol store
	detp_ram #(.WIDTH(SYM_W), .DEPTH(CAPACITY)) u_sym (
		.clk   (clk),
		.we    (cmd.start),
		.waddr (push_cmd == CMD_FRONT ? SW'(fi_q) : SW'(bi_q)),
		.wdata (push_symbol),
		.raddr (SW'(p_q)),
		.rdata (sym_rdata)
	);

	// node table: length, suffix link, depth
	detp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_MAX)) u_node (
		.clk   (clk),
		.we    (cmd.depth_use),
		.waddr (new_q),
		.wdata ({new_len_q, cur_q, DW'(nd_dep + DW'(1))}),
		.raddr (cur_q),
		.rdata (node_rdata)
	);

	// child table, swept to zero after reset and restart
	assign child_we    = cmd.clr_step | cmd.create;
	assign child_waddr = cmd.clr_step ? clr_q : caddr_q;
	assign child_wdata = cmd.clr_step ? '0 : NW'(ncount_q);

	detp_ram #(.WIDTH(NW), .DEPTH(CHD)) u_child (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (caddr_q),
		.rdata (child_rdata)
	);

	// roots are constants, others come from the node table
	always_comb begin
		nd_len  = $signed(node_rdata[NODE_W-1 -: PW]);
		nd_link = node_rdata[DW +: NW];
		nd_dep  = node_rdata[DW-1:0];
		if (cur_q == NW'(ODD_ROOT)) begin
			nd_len  = PW'(-1);
			nd_link = NW'(ODD_ROOT);
			nd_dep  = '0;
		end else if (cur_q == NW'(EVEN_ROOT)) begin
			nd_len  = '0;
			nd_link = NW'(ODD_ROOT);
			nd_dep  = '0;
		end
	end

	// mirror position and misc
	always_comb begin
		if (front_q == CMD_FRONT) p_nxt = PPW'(fi_q) + PPW'(nd_len) + PPW'(2);
		else p_nxt = PPW'(bi_q) - PPW'(nd_len) - PPW'(2);
		room = (32'(cfg_data) > CAPACITY) ? CAP_P : PW'(cfg_data);
		sel_len = (push_cmd == CMD_FRONT) ? pre_len_q : suf_len_q;
		total_nxt = total_q + TOTAL_W'(end_depth_q);
	end

	// status to controller
	always_comb begin
		stat.rej = (32'(push_symbol) >= ALPHABET) ||
			(push_cmd == CMD_FRONT && fi_q < 0) ||
			(push_cmd == CMD_BACK && bi_q >= CAP_P);
		stat.clr_last   = (clr_q == CW'(CHD - 1));
		stat.match      = inr_q && (sym_rdata == c_q);
		stat.child_zero = (child_rdata == '0);
		stat.len_odd    = (len_q == PW'(-1));
	end

	// string ends, end nodes, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q      <= PW'(-1);
			bi_q      <= '0;
			pre_q     <= NW'(ODD_ROOT);
			suf_q     <= NW'(ODD_ROOT);
			pre_len_q <= PW'(-1);
			suf_len_q <= PW'(-1);
			ncount_q  <= NCW'(2);
			total_q   <= '0;
			clr_q     <= '0;
		end else if (cmd.restart) begin
			fi_q      <= room - PW'(1);
			bi_q      <= room;
			pre_q     <= NW'(ODD_ROOT);
			suf_q     <= NW'(ODD_ROOT);
			pre_len_q <= PW'(-1);
			suf_len_q <= PW'(-1);
			ncount_q  <= NCW'(2);
			total_q   <= '0;
			clr_q     <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + CW'(1);
			if (cmd.start) begin
				if (push_cmd == CMD_FRONT) fi_q <= fi_q - PW'(1);
				else bi_q <= bi_q + PW'(1);
			end
			if (cmd.create) ncount_q <= ncount_q + NCW'(1);
			if (cmd.finish) begin
				total_q <= total_nxt;
				if (front_q == CMD_FRONT) begin
					pre_q     <= end_q;
					pre_len_q <= end_len_q;
					if (end_len_q == bi_q - fi_q - PW'(1)) begin
						suf_q     <= end_q;
						suf_len_q <= end_len_q;
					end
				end else begin
					suf_q     <= end_q;
					suf_len_q <= end_len_q;
					if (end_len_q == bi_q - fi_q - PW'(1)) begin
						pre_q     <= end_q;
						pre_len_q <= end_len_q;
					end
				end
			end
		end
	end

	// walk and creation registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			front_q <= push_cmd;
			c_q     <= push_symbol;
			cur_q   <= (push_cmd == CMD_FRONT) ? pre_q : suf_q;
		end
		if (cmd.node_use) begin
			len_q  <= nd_len;
			link_q <= nd_link;
			p_q    <= p_nxt;
			inr_q  <= (p_nxt > PPW'(fi_q)) && (p_nxt < PPW'(bi_q)) && (p_nxt < CAP_PP);
		end
		if (cmd.walk_next) cur_q <= link_q;
		if (cmd.caddr_load) caddr_q <= CW'(32'(cur_q) * ALPHABET + 32'(c_q));
		if (cmd.create) begin
			new_q     <= NW'(ncount_q);
			new_len_q <= len_q + PW'(2);
		end
		if (cmd.link_even) cur_q <= NW'(EVEN_ROOT);
		if (cmd.phase1) cur_q <= link_q;
		if (cmd.hit || cmd.link_found) cur_q <= child_rdata;
		if (cmd.depth_use) begin
			end_q       <= new_q;
			end_len_q   <= new_len_q;
			end_depth_q <= DW'(nd_dep + DW'(1));
		end
		if (cmd.end_use) begin
			end_q       <= cur_q;
			end_len_q   <= nd_len;
			end_depth_q <= nd_dep;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			total_palindromes    <= total_q;
			distinct_palindromes <= COUNT_W'(ncount_q - NCW'(2));
			end_palindrome_len   <= len_out(sel_len);
			status               <= STATUS_REJECT;
		end
		if (cmd.finish) begin
			total_palindromes    <= total_nxt;
			distinct_palindromes <= COUNT_W'(ncount_q - NCW'(2));
			end_palindrome_len   <= len_out(end_len_q);
			status               <= STATUS_OK;
		end
	end

endmodule

[src/double_ended_palindrome_tree_top.sv]
// palindromic tree over a string that grows at both ends
// push channel: cmd (0 back, 1 front) and symbol; one request in flight
// result channel: running occurrence total, distinct palindrome count,
//   longest palindrome length at the extended end, and a status bit
// cfg channel: writes front_room and restarts string and tree
// an accepted push shows its result after the walks; each suffix link step
//   of the walks adds to the wait, and so does a new node that needs a
//   second walk for its own suffix link; the wait is set by the node table,
//   symbol store and child table reads that each step chains
// the next push is taken only once the result has been taken, so one push
//   is handled at a time
// a rejected push (side full or symbol out of range) skips the walks
// the result is held until taken; no new push is accepted before that,
//   so a stalled receiver stalls the push channel
// after reset and after each front_room write the child table is swept
//   to zero, all (CAPACITY+2)*ALPHABET entries, with push ready low meanwhile
module double_ended_palindrome_tree_top #(
	parameter int CAPACITY = detp_pkg::DEF_CAPACITY,
	parameter int ALPHABET = detp_pkg::DEF_ALPHABET
) (
	input  logic          clk,
	input  logic          arst_n,
	detp_push_if.sink     push,
	detp_result_if.source result,
	detp_cfg_if.sink      cfg
);
	import detp_pkg::*;

	detp_cmd_t  cmd;
	detp_stat_t stat;
	logic       cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	// sequencer
	detp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_valid   (push.valid),
		.result_ready (result.ready),
		.cfg_fire     (cfg_fire),
		.stat         (stat),
		.cmd          (cmd),
		.push_ready   (push.ready),
		.result_valid (result.valid)
	);

	// tables and registers
	detp_dp #(.CAPACITY(CAPACITY), .ALPHABET(ALPHABET)) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.push_cmd             (push.cmd),
		.push_symbol          (push.symbol),
		.cfg_data             (cfg.data),
		.total_palindromes    (result.total_palindromes),
		.distinct_palindromes (result.distinct_palindromes),
		.end_palindrome_len   (result.end_palindrome_len),
		.status               (result.status)
	);

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push.ready && result.valid))
		else $error("push ready while result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.ready && !cfg_fire |=> !push.ready)
		else $error("push accepted twice in a row");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready |=> !result.valid)
		else $error("result delivered twice");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.create |-> stat.child_zero)
		else $error("node created over an existing child");

endmodule

[bench/detp_checker.sv]
module detp_checker #(
	parameter int CAPACITY = detp_pkg::DEF_CAPACITY,
	parameter int ALPHABET = detp_pkg::DEF_ALPHABET
) (
	input  logic   clk,
	input  logic   arst_n,
	detp_push_if   push,
	detp_result_if result,
	detp_cfg_if    cfg,
	output int     errors,
	output int     pending
);
	import detp_pkg::*;

	localparam int NODES = CAPACITY + 2;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [COUNT_W-1:0] distinct;
		logic [LEN_W-1:0]   len;
		logic               status;
	} tree_result_t;

	// mirror of the string and the tree
	logic [SYM_W-1:0] sym_mem [CAPACITY];
	int               kid [NODES*ALPHABET];
	int               nlen [NODES];
	int               nlink [NODES];
	int               ndep [NODES];
	int               fidx, bidx, pre_node, suf_node, ncount;
	logic [TOTAL_W-1:0] occ;
	logic [ROOM_W-1:0]  room;
	tree_result_t     expected_q [$];

	function automatic void clear_tree();
		int r;
		r = (room > CAPACITY) ? CAPACITY : int'(room);
		foreach (sym_mem[i]) sym_mem[i] = '0;
		foreach (kid[i]) kid[i] = 0;
		foreach (nlen[i]) begin
			nlen[i] = 0;
			nlink[i] = 0;
			ndep[i] = 0;
		end
		nlen[ODD_ROOT] = -1;
		nlink[ODD_ROOT] = ODD_ROOT;
		nlink[EVEN_ROOT] = ODD_ROOT;
		fidx = r - 1;
		bidx = r;
		pre_node = ODD_ROOT;
		suf_node = ODD_ROOT;
		ncount = 2;
		occ = '0;
	endfunction

	// follow suffix links until node n can be wrapped by symbol c
	function automatic int find_wrap(bit front, int n, int c);
		int p;
		while (1) begin
			p = front ? fidx + nlen[n] + 2 : bidx - nlen[n] - 2;
			if (p > fidx && p < bidx && p < CAPACITY && sym_mem[p] == c)
				return n;
			if (n == ODD_ROOT)
				return n;
			n = nlink[n];
		end
	endfunction

	// add symbol c on one end, creating at most one node
	function automatic int grow_end(bit front, int start, int c);
		int t, f, nn;
		t = find_wrap(front, start, c);
		nn = kid[t*ALPHABET + c];
		if (nn != 0)
			return nn;
		nn = ncount;
		ncount++;
		nlen[nn] = nlen[t] + 2;
		kid[t*ALPHABET + c] = nn;
		if (nlen[nn] == 1) begin
			nlink[nn] = EVEN_ROOT;
		end else begin
			f = find_wrap(front, nlink[t], c);
			nlink[nn] = kid[f*ALPHABET + c];
		end
		ndep[nn] = ndep[nlink[nn]] + 1;
		return nn;
	endfunction

	function automatic tree_result_t apply_push(logic cmd, logic [SYM_W-1:0] sym);
		tree_result_t r;
		int c, en;
		bit front;
		c = int'(sym);
		front = (cmd == CMD_FRONT);
		r.status = STATUS_OK;
		if (c >= ALPHABET || (front && fidx < 0) || (!front && bidx >= CAPACITY)) begin
			r.status = STATUS_REJECT;
			en = front ? pre_node : suf_node;
		end else if (front) begin
			sym_mem[fidx] = sym;
			fidx--;
			pre_node = grow_end(1'b1, pre_node, c);
			if (nlen[pre_node] == bidx - fidx - 1)
				suf_node = pre_node;
			occ = occ + TOTAL_W'(ndep[pre_node]);
			en = pre_node;
		end else begin
			sym_mem[bidx] = sym;
			bidx++;
			suf_node = grow_end(1'b0, suf_node, c);
			if (nlen[suf_node] == bidx - fidx - 1)
				pre_node = suf_node;
			occ = occ + TOTAL_W'(ndep[suf_node]);
			en = suf_node;
		end
		r.total = occ;
		r.distinct = COUNT_W'(ncount - 2);
		r.len = (nlen[en] > 0) ? LEN_W'(nlen[en]) : '0;
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		room = '0;
		clear_tree();
	end

	// watch the three channels
	always @(posedge clk) begin
		tree_result_t got, want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				room = cfg.data;
				clear_tree();
			end
			if (result.valid && result.ready) begin
				got.total = result.total_palindromes;
				got.distinct = result.distinct_palindromes;
				got.len = result.end_palindrome_len;
				got.status = result.status;
				if (expected_q.size() == 0) begin
					$error("result with no request waiting");
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.total !== want.total) begin
						$error("total_palindromes expected %0d got %0d", want.total, got.total);
						errors++;
					end
					if (got.distinct !== want.distinct) begin
						$error("distinct_palindromes expected %0d got %0d",
							want.distinct, got.distinct);
						errors++;
					end
					if (got.len !== want.len) begin
						$error("end_palindrome_len expected %0d got %0d", want.len, got.len);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						errors++;
					end
				end
			end
			if (push.valid && push.ready)
				expected_q = {expected_q, apply_push(push.cmd, push.symbol)};
			pending = expected_q.size();
		end
	end
endmodule

[bench/tb.sv]
module tb;
	import detp_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   calm;

	detp_push_if   push ();
	detp_result_if result ();
	detp_cfg_if    cfg ();

	double_ended_palindrome_tree_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.result (result),
		.cfg    (cfg)
	);

	detp_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.result  (result),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	initial begin
		#(12 * 3000000);
		$display("FAIL double_ended_palindrome_tree_top");
		$finish;
	end

	// result receiver with random stalls
	initial begin
		int k;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			k = calm ? 0 : $urandom_range(0, 15);
			if (k > 0) begin
				result.ready = 1'b0;
				repeat (k) @(negedge clk);
			end
			result.ready = 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// one push request; valid stays high when no gap follows
	task automatic send_push(logic c, logic [SYM_W-1:0] s);
		int k;
		k = calm ? 0 : $urandom_range(0, 15);
		if (k > 0) begin
			push.valid = 1'b0;
			repeat (k) @(negedge clk);
		end
		push.cmd = c;
		push.symbol = s;
		push.valid = 1'b1;
		do @(posedge clk); while (!push.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		push.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// room write while idle
	task automatic set_room(logic [ROOM_W-1:0] r);
		drain();
		cfg.data = r;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// mostly short-alphabet strings, some mirrored pairs, a few bad symbols
	task automatic random_phase(int count, int back_pct);
		int i, pick;
		logic [SYM_W-1:0] s;
		logic c;
		for (i = 0; i < count; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				s = SYM_W'($urandom_range(0, 2));
			else if (pick < 95)
				s = SYM_W'($urandom_range(0, 25));
			else
				s = SYM_W'($urandom_range(26, 31));
			c = ($urandom_range(0, 99) < back_pct) ? CMD_BACK : CMD_FRONT;
			if ($urandom_range(0, 99) < 25) begin
				send_push(CMD_FRONT, s);
				send_push(CMD_BACK, s);
				i++;
			end else begin
				send_push(c, s);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		push.valid = 1'b0;
		push.cmd = CMD_BACK;
		push.symbol = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no front room: front pushes rejected, bad symbols rejected
		send_push(CMD_FRONT, 5'd0);
		send_push(CMD_BACK, 5'd0);
		send_push(CMD_BACK, 5'd25);
		send_push(CMD_BACK, 5'd0);
		send_push(CMD_BACK, 5'd26);
		send_push(CMD_BACK, 5'd31);
		send_push(CMD_FRONT, 5'd25);
		random_phase(250, 50);

		// tiny front room fills quickly
		set_room(11'd3);
		send_push(CMD_FRONT, 5'd1);
		send_push(CMD_FRONT, 5'd1);
		send_push(CMD_BACK, 5'd1);
		send_push(CMD_FRONT, 5'd2);
		send_push(CMD_FRONT, 5'd1);
		send_push(CMD_BACK, 5'd30);
		send_push(CMD_BACK, 5'd2);
		send_push(CMD_BACK, 5'd1);
		random_phase(150, 50);

		// all room at the front, back side full from the start
		set_room(11'd1024);
		random_phase(150, 50);

		// oversized room acts as full capacity
		set_room(11'd2047);
		random_phase(100, 50);

		// short back side that fills
		set_room(11'd1000);
		random_phase(400, 80);

		// even split, with a full drain in the middle
		set_room(11'd512);
		random_phase(200, 50);
		drain();
		random_phase(200, 50);

		set_room(11'd1);
		random_phase(150, 50);

		set_room(ROOM_W'($urandom_range(0, 1024)));
		random_phase(100, 50);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS double_ended_palindrome_tree_top");
		else
			$display("FAIL double_ended_palindrome_tree_top");
		$finish;
	end
endmodule
